// File: design/bitmap_inode_block_allocator_macros.svh
// Assertion macros shared by the allocator's checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef BITMAP_INODE_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_INODE_BLOCK_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bia_pkg.sv
// Shared types and constants of the bitmap inode and block allocator.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package bia_pkg;

    localparam int TOTAL_W = 14;
    localparam int DEF_MAP_BYTES = 1024;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 14'd8192;

    typedef logic [1:0] status_t;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_NONE_FREE = 2'd1;
    localparam status_t STAT_RANGE     = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic SEL_INODE = 1'b0;
    localparam logic SEL_BLOCK = 1'b1;

    localparam logic REG_INODE_TOTAL = 1'b0;
    localparam logic REG_BLOCK_TOTAL = 1'b1;

endpackage

`default_nettype wire

// File: design/bitmap_inode_block_allocator.sv
// An allocate sets the first clear bit it finds in the map; a free reads the word and
// clears the bit; a free out of range skips the memory. One item is in work at a time.
// The scan reads one bitmap word per cycle from the selected map memory.
// After reset the block clears both map memories before
// it takes the first transaction; configuration writes are taken throughout.
// Top level of the allocator; depends on bia_pkg.
`default_nettype none

module bitmap_inode_block_allocator #(
    parameter int MAP_BYTES = bia_pkg::DEF_MAP_BYTES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [bia_pkg::TOTAL_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic                          map_select,
    input  wire logic [bia_pkg::TOTAL_W-1:0]   item_number,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bia_pkg::TOTAL_W-1:0]        granted_number,
    output logic [1:0]                         status,
    output logic [bia_pkg::TOTAL_W-1:0]        free_inodes,
    output logic [bia_pkg::TOTAL_W-1:0]        free_blocks
);

    localparam int TW        = bia_pkg::TOTAL_W;
    localparam int MAP_WORDS = MAP_BYTES / 4;
    localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int MAP_BITS  = MAP_BYTES * 8;
    localparam int TOTAL_MAX = (2 ** TW) - 1;
    localparam int CAP_INT   = (MAP_BITS > TOTAL_MAX) ? TOTAL_MAX : MAP_BITS;
    localparam logic [TW-1:0] CAP_BITS = TW'(CAP_INT);
    localparam int LW        = TW - 4;
    localparam int CW        = (WA + 1 > LW) ? WA + 1 : LW;
    localparam int IW        = (WA + 5 > TW) ? WA + 5 : TW;
    localparam logic [CW-1:0] WORDS_C  = CW'(MAP_WORDS);
    localparam logic [WA-1:0] LAST_ADR = WA'(MAP_WORDS - 1);
    localparam logic [31:0]   ADR_MASK = 32'(MAP_WORDS - 1);
    localparam logic [TW-1:0] USED_MAX = TW'(TOTAL_MAX);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_FREE_RD = 3'd3;
    localparam logic [2:0] ST_FREE_WR = 3'd4;
    localparam logic [2:0] ST_RESP    = 3'd5;

    function automatic logic [TW-1:0] eff_total(input logic [TW-1:0] t);
        eff_total = (t > CAP_BITS) ? CAP_BITS : t;
    endfunction

    function automatic logic [TW-1:0] free_cnt(input logic [TW-1:0] t,
                                               input logic [TW-1:0] used);
        logic [TW-1:0] e;
        e = eff_total(t);
        free_cnt = (used >= e) ? '0 : e - used;
    endfunction

    // Map memories with registered read data.
    logic [31:0] ino_mem [MAP_WORDS];
    logic [31:0] blk_mem [MAP_WORDS];
    logic [31:0] ino_q_reg;
    logic [31:0] blk_q_reg;

    logic [2:0]       state_reg, state_next;
    logic [WA-1:0]    clr_reg, clr_next;
    logic             sel_reg, sel_next;
    logic [TW-1:0]    idx_reg, idx_next;
    logic [WA:0]      w_reg, w_next;
    logic [WA-1:0]    chk_reg, chk_next;
    logic             pend_reg, pend_next;
    logic [TW-1:0]    grant_reg, grant_next;
    bia_pkg::status_t stat_reg, stat_next;
    logic [TW-1:0]    ino_used_reg, ino_used_next;
    logic [TW-1:0]    blk_used_reg, blk_used_next;
    logic [TW-1:0]    ino_total_reg, blk_total_reg;
    logic             out_valid_reg, out_valid_next;
    logic [TW-1:0]    out_grant_reg;
    bia_pkg::status_t out_stat_reg;
    logic [TW-1:0]    out_fi_reg, out_fb_reg;

    logic             mem_re;
    logic [WA-1:0]    mem_addr;
    logic [31:0]      mem_wdata;
    logic             ino_we, blk_we;
    logic             load_out;

    logic [31:0]      rd_word;
    logic [31:0]      clear_bits;
    logic             bit_found;
    logic [4:0]       bit_pos;
    logic [TW-1:0]    eff_sel;
    logic [TW-1:0]    eff_in;
    logic [CW-1:0]    word_lim;
    logic             scan_issue;
    logic [IW-1:0]    found_idx;
    logic [TW-1:0]    in_idx;
    logic [31:0]      free_adr_wide;
    logic             used_up, used_down;
    logic [TW-1:0]    used_sel;

    assign rd_word    = sel_reg ? blk_q_reg : ino_q_reg;
    assign clear_bits = ~rd_word;
    assign eff_sel    = eff_total(sel_reg ? blk_total_reg : ino_total_reg);
    assign eff_in     = eff_total(map_select ? blk_total_reg : ino_total_reg);
    assign in_idx     = item_number - TW'(1);
    assign used_sel   = sel_reg ? blk_used_reg : ino_used_reg;

    // A word is worth reading while its first bit lies below the total.
    assign word_lim   = CW'(((TW+1)'(eff_sel) + (TW+1)'(31)) >> 5);
    assign scan_issue = (CW'(w_reg) < WORDS_C) && (CW'(w_reg) < word_lim);
    assign found_idx  = IW'({chk_reg, 5'd0}) | IW'(bit_pos);
    assign free_adr_wide = 32'(idx_reg >> 5) & ADR_MASK;

    always_comb
    begin
        bit_found = 1'b0;
        bit_pos   = '0;
        for (int b = 31; b >= 0; b--)
        begin
            if (clear_bits[b])
            begin
                bit_found = 1'b1;
                bit_pos   = 5'(b);
            end
        end
    end

    assign load_out = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        sel_next   = sel_reg;
        idx_next   = idx_reg;
        w_next     = w_reg;
        chk_next   = chk_reg;
        pend_next  = 1'b0;
        grant_next = grant_reg;
        stat_next  = stat_reg;
        used_up    = 1'b0;
        used_down  = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = '0;
        mem_wdata  = '0;
        ino_we     = 1'b0;
        blk_we     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_addr = clr_reg;
                ino_we   = 1'b1;
                blk_we   = 1'b1;
                clr_next = clr_reg + WA'(1);
                if (clr_reg == LAST_ADR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sel_next   = map_select;
                    idx_next   = in_idx;
                    w_next     = '0;
                    grant_next = '0;
                    stat_next  = bia_pkg::STAT_OK;
                    if (kind == bia_pkg::KIND_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (item_number == '0 || item_number > eff_in)
                    begin
                        stat_next  = bia_pkg::STAT_RANGE;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_FREE_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                // One read is issued per cycle; the word read last cycle is checked now.
                if (pend_reg && bit_found)
                begin
                    state_next = ST_RESP;
                    if (found_idx >= IW'(eff_sel))
                    begin
                        stat_next = bia_pkg::STAT_NONE_FREE;
                    end
                    else
                    begin
                        mem_addr   = chk_reg;
                        mem_wdata  = rd_word | (32'd1 << bit_pos);
                        ino_we     = (sel_reg == bia_pkg::SEL_INODE);
                        blk_we     = (sel_reg == bia_pkg::SEL_BLOCK);
                        grant_next = TW'(found_idx + IW'(1));
                        used_up    = 1'b1;
                    end
                end
                else if (scan_issue)
                begin
                    mem_re    = 1'b1;
                    mem_addr  = w_reg[WA-1:0];
                    chk_next  = w_reg[WA-1:0];
                    w_next    = w_reg + (WA+1)'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    stat_next  = bia_pkg::STAT_NONE_FREE;
                    state_next = ST_RESP;
                end
            end
            ST_FREE_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = free_adr_wide[WA-1:0];
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                mem_addr   = free_adr_wide[WA-1:0];
                mem_wdata  = rd_word & ~(32'd1 << idx_reg[4:0]);
                ino_we     = (sel_reg == bia_pkg::SEL_INODE);
                blk_we     = (sel_reg == bia_pkg::SEL_BLOCK);
                used_down  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Used counters saturate at both ends.
    always_comb
    begin
        logic [TW-1:0] upd;
        upd = used_sel;
        if (used_up && used_sel < USED_MAX)
        begin
            upd = used_sel + TW'(1);
        end
        else if (used_down && used_sel > '0)
        begin
            upd = used_sel - TW'(1);
        end
        ino_used_next = (sel_reg == bia_pkg::SEL_INODE) ? upd : ino_used_reg;
        blk_used_next = (sel_reg == bia_pkg::SEL_BLOCK) ? upd : blk_used_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ino_we)
        begin
            ino_mem[mem_addr] <= mem_wdata;
        end
        if (blk_we)
        begin
            blk_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            ino_q_reg <= ino_mem[mem_addr];
            blk_q_reg <= blk_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            ino_used_reg  <= '0;
            blk_used_reg  <= '0;
            ino_total_reg <= bia_pkg::TOTAL_RESET;
            blk_total_reg <= bia_pkg::TOTAL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            ino_used_reg  <= ino_used_next;
            blk_used_reg  <= blk_used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bia_pkg::REG_INODE_TOTAL: ino_total_reg <= cfg_data;
                    bia_pkg::REG_BLOCK_TOTAL: blk_total_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg   <= sel_next;
        idx_reg   <= idx_next;
        w_reg     <= w_next;
        chk_reg   <= chk_next;
        grant_reg <= grant_next;
        stat_reg  <= stat_next;
        if (load_out)
        begin
            out_grant_reg <= grant_reg;
            out_stat_reg  <= stat_reg;
            out_fi_reg    <= free_cnt(ino_total_reg, ino_used_reg);
            out_fb_reg    <= free_cnt(blk_total_reg, blk_used_reg);
        end
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign granted_number = out_grant_reg;
    assign status         = out_stat_reg;
    assign free_inodes    = out_fi_reg;
    assign free_blocks    = out_fb_reg;

endmodule

`default_nettype wire

// File: design/bia_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on bia_pkg and bitmap_inode_block_allocator_macros.svh.
`default_nettype none
`include "bitmap_inode_block_allocator_macros.svh"

module bia_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [bia_pkg::TOTAL_W-1:0] granted_number,
    input wire logic [1:0]                  status
);

    `BIA_ASSERT_SAME(a_status_legal, out_valid, status == bia_pkg::STAT_OK || status == bia_pkg::STAT_NONE_FREE || status == bia_pkg::STAT_RANGE, "status code out of range")

    `BIA_ASSERT_SAME(a_fail_no_grant, out_valid && status != bia_pkg::STAT_OK, granted_number == '0, "failed transaction carries a granted number")

    // Only one transaction is in work, so the input side closes after an accept.
    `BIA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready right after an accept")

    `BIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(granted_number) && $stable(status), "stalled result changed")

endmodule

bind bitmap_inode_block_allocator bia_checker u_bia_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted_number (granted_number),
    .status         (status)
);

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for bitmap_inode_block_allocator: a scoreboard class keeps
// its own copy of both bitmaps, the used counters and the totals, and checks every reply.
// Depends on bia_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;

    localparam int MAP_BITS = bia_pkg::DEF_MAP_BYTES * 8;
    localparam int USED_MAX = (1 << bia_pkg::TOTAL_W) - 1;
    localparam int ITEMS_PER_PHASE = 153;
    localparam int PHASES = 12;

    typedef logic [bia_pkg::TOTAL_W-1:0] count_t;

    typedef struct packed {
        count_t           granted;
        bia_pkg::status_t code;
        count_t           inodes_free;
        count_t           blocks_free;
    } reply_t;

    class bitmap_scoreboard;
        bit     taken [2][MAP_BITS];
        count_t used [2];
        count_t total [2];
        reply_t expected_replies [$];
        int unsigned errors;
        int unsigned grants;
        int unsigned exhausted;
        int unsigned rejected;

        function new();
            used[bia_pkg::SEL_INODE] = '0;
            used[bia_pkg::SEL_BLOCK] = '0;
            total[bia_pkg::SEL_INODE] = bia_pkg::TOTAL_RESET;
            total[bia_pkg::SEL_BLOCK] = bia_pkg::TOTAL_RESET;
            errors = 0;
            grants = 0;
            exhausted = 0;
            rejected = 0;
        endfunction

        // A total above the bitmap capacity acts as the capacity.
        function int unsigned usable(logic s);
            return (total[s] > MAP_BITS) ? MAP_BITS : int'(total[s]);
        endfunction

        function count_t remaining(logic s);
            int unsigned t;
            t = usable(s);
            return (used[s] >= t) ? count_t'(0) : count_t'(t - used[s]);
        endfunction

        function void set_totals(count_t inode_limit, count_t block_limit);
            total[bia_pkg::SEL_INODE] = inode_limit;
            total[bia_pkg::SEL_BLOCK] = block_limit;
        endfunction

        // Applies one accepted request and queues the reply it must produce.
        function count_t note_request(logic k, logic s, count_t num);
            reply_t r;
            int unsigned t;
            int unsigned i;
            t = usable(s);
            r.granted = '0;
            r.code = bia_pkg::STAT_OK;
            if (k == bia_pkg::KIND_ALLOC)
            begin
                for (i = 0; i < t && r.granted == 0; i++)
                begin
                    if (!taken[s][i])
                    begin
                        taken[s][i] = 1'b1;
                        r.granted = count_t'(i + 1);
                    end
                end
                if (r.granted == 0)
                begin
                    r.code = bia_pkg::STAT_NONE_FREE;
                    exhausted++;
                end
                else
                begin
                    grants++;
                    if (used[s] < USED_MAX)
                        used[s]++;
                end
            end
            else if (num == 0 || num > t)
            begin
                r.code = bia_pkg::STAT_RANGE;
                rejected++;
            end
            else
            begin
                // Freeing a clear bit still lowers the counter.
                taken[s][num - 1] = 1'b0;
                if (used[s] > 0)
                    used[s]--;
            end
            r.inodes_free = remaining(bia_pkg::SEL_INODE);
            r.blocks_free = remaining(bia_pkg::SEL_BLOCK);
            expected_replies.push_back(r);
            return r.granted;
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_reply(count_t g, bia_pkg::status_t c, count_t fi, count_t fb);
            reply_t r;
            if (expected_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply with nothing outstanding, granted_number %0d status %0d",
                         $time, g, c);
                return;
            end
            r = expected_replies.pop_front();
            compare("granted_number", 32'(r.granted), 32'(g));
            compare("status", 32'(r.code), 32'(c));
            compare("free_inodes", 32'(r.inodes_free), 32'(fi));
            compare("free_blocks", 32'(r.blocks_free), 32'(fb));
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    cfg_write;
    logic    cfg_index;
    count_t  cfg_data;
    logic    in_valid;
    logic    in_ready;
    logic    kind;
    logic    map_select;
    count_t  item_number;
    logic    out_valid;
    logic    out_ready = 1'b0;
    count_t  granted_number;
    logic [1:0] status;
    count_t  free_inodes;
    count_t  free_blocks;

    bitmap_scoreboard sb = new();
    logic        steady = 1'b0;
    count_t      high_water [2];
    int unsigned settings_used = 0;
    int unsigned inode_plan [PHASES] = '{8192, 40, 16383, 1, 0, 97, 32, 8191, 5, 300, 64, 8192};
    int unsigned block_plan [PHASES] = '{8192, 70, 5, 8192, 33, 0, 31, 64, 16383, 2, 300, 1};

    bitmap_inode_block_allocator DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 32);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply(granted_number, status, free_inodes, free_blocks);
    end

    // Presents one request and returns once the transaction is accepted.
    task automatic send_item(input logic k, input logic s, input count_t num);
        count_t granted;
        int unsigned gap;
        @(negedge clk);
        if (!steady && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        kind <= k;
        map_select <= s;
        item_number <= num;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        granted = sb.note_request(k, s, num);
        if (granted > high_water[s])
            high_water[s] = granted;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_totals(input count_t inode_limit, input count_t block_limit);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= bia_pkg::REG_INODE_TOTAL;
        cfg_data <= inode_limit;
        @(negedge clk);
        cfg_index <= bia_pkg::REG_BLOCK_TOTAL;
        cfg_data <= block_limit;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_totals(inode_limit, block_limit);
        settings_used++;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned n;
        int unsigned r;
        int unsigned te;
        int unsigned lim;
        int unsigned inode_limit;
        logic s;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = bia_pkg::REG_INODE_TOTAL;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = bia_pkg::KIND_ALLOC;
        map_select = bia_pkg::SEL_INODE;
        item_number = '0;
        high_water[bia_pkg::SEL_INODE] = '0;
        high_water[bia_pkg::SEL_BLOCK] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default totals: range edges, freeing a clear bit, counter floor at zero.
        send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_INODE, 14'h3FFF);
        send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_BLOCK, 14'd0);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_INODE, 14'd0);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_INODE, 14'd8193);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_INODE, 14'h3FFF);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_BLOCK, 14'd8192);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_BLOCK, 14'd1);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_INODE, 14'd1);
        drain();

        // Zero total on one map, total above capacity on the other.
        write_totals(14'd0, 14'h3FFF);
        send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_INODE, 14'd0);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_INODE, 14'd1);
        send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_BLOCK, 14'd0);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_BLOCK, 14'd8192);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_BLOCK, 14'd8193);
        drain();

        // Tiny totals: exhaust both maps, then refill a hole first-fit.
        write_totals(14'd3, 14'd1);
        repeat (4) send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_INODE,
                             count_t'($urandom_range(16383, 0)));
        repeat (2) send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_BLOCK,
                             count_t'($urandom_range(16383, 0)));
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_INODE, 14'd2);
        send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_INODE, 14'd0);
        drain();

        // Total lowered below the used count.
        write_totals(14'd1, 14'd1);
        send_item(bia_pkg::KIND_ALLOC, bia_pkg::SEL_INODE, 14'd0);
        send_item(bia_pkg::KIND_FREE, bia_pkg::SEL_INODE, 14'd3);
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            inode_limit = (phase == 9) ? $urandom_range(200, 2) : inode_plan[phase];
            write_totals(count_t'(inode_limit), count_t'(block_plan[phase]));
            steady = (phase == 3);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                s = 1'($urandom_range(1, 0));
                r = $urandom_range(99);
                te = sb.usable(s);
                lim = (high_water[s] < te) ? high_water[s] : te;
                // Mostly allocations and frees of numbers likely to be in use.
                if (r < 50)
                    send_item(bia_pkg::KIND_ALLOC, s, count_t'($urandom_range(16383, 0)));
                else if (r < 85 && lim > 0)
                    send_item(bia_pkg::KIND_FREE, s, count_t'($urandom_range(lim, 1)));
                else if (r < 95 && te > 0)
                    send_item(bia_pkg::KIND_FREE, s, count_t'($urandom_range(te, 1)));
                else
                    send_item(bia_pkg::KIND_FREE, s, count_t'($urandom_range(16383, 0)));
            end
            steady = 1'b0;
            drain();
        end

        repeat (10) @(posedge clk);
        $display("summary: %0d total settings, %0d grants, %0d allocations found nothing,",
                 settings_used, sb.grants, sb.exhausted);
        $display("summary: %0d frees rejected as out of range, %0d mismatches",
                 sb.rejected, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
